// ===== src/perspective_inverse_map_defines.svh =====
// Assertion helpers for the perspective mapper sources; only pim_queue includes them.
`ifndef PERSPECTIVE_INVERSE_MAP_DEFINES_SVH
`define PERSPECTIVE_INVERSE_MAP_DEFINES_SVH

`ifndef SYNTHESIS
`define PIM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PIM_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define PIM_ASSERT(lbl, clk, rst, prop, msg)
`define PIM_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// ===== src/pim_pkg.sv =====
package pim_pkg;

   localparam int COORD_BITS_DEF     = 12;
   localparam int COEF_FRAC_BITS_DEF = 20;
   localparam int OUT_FRAC_BITS_DEF  = 16;

   localparam int COEF_W    = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W = 8;
   localparam int OUT_W     = 32;
   localparam int STATUS_W  = 2;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_01 = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_23 = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_45 = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_67 = 8'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_8  = 8'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WZERO = 2'd2;

   // width of a signed sum of two coefficient-by-coordinate terms and one coefficient
   function automatic int sum_width(input int coord_bits);
      return COEF_W + coord_bits + 3;
   endfunction

endpackage

// ===== src/pim_front.sv =====
module pim_front
   import pim_pkg::*;
#(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int IN_W           = ((2 * COORD_BITS + 7) / 8) * 8,
   parameter int SUM_W          = sum_width(COORD_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_W-1:0]        req_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push,
   output logic [3*SUM_W-1:0]     push_data,
   input  logic                   full
);

   localparam int PROD_W = COEF_W + COORD_BITS + 1;
   localparam logic [CSR_DATA_W-1:0] ONE_PAIR = CSR_DATA_W'(1) << COEF_FRAC_BITS;
   localparam logic [COEF_W-1:0]     ONE_COEF = COEF_W'(1) << COEF_FRAC_BITS;

   logic [CSR_DATA_W-1:0] pair01_ff, pair23_ff, pair45_ff, pair67_ff;
   logic [COEF_W-1:0]     coef8_ff;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [COORD_BITS-1:0] x1_ff, y1_ff;
   logic signed [PROD_W-1:0] p_ff [0:5];
   logic signed [PROD_W-1:0] p_in [0:5];
   logic signed [COEF_W-1:0] c2_ff, c5_ff, c8_ff;
   logic signed [SUM_W-1:0]  xp_ff, yp_ff, w_ff;
   logic signed [SUM_W-1:0]  xp_in, yp_in, w_in;
   logic signed [COORD_BITS:0] xs, ys;
   logic signed [COEF_W-1:0] m [0:8];
   logic en;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair01_ff <= ONE_PAIR;
         pair23_ff <= '0;
         pair45_ff <= ONE_PAIR;
         pair67_ff <= '0;
         coef8_ff  <= ONE_COEF;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PAIR_01: pair01_ff <= csr_data;
            CSR_PAIR_23: pair23_ff <= csr_data;
            CSR_PAIR_45: pair45_ff <= csr_data;
            CSR_PAIR_67: pair67_ff <= csr_data;
            CSR_COEF_8:  coef8_ff  <= csr_data[COEF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      m[0] = pair01_ff[COEF_W-1:0];
      m[1] = pair01_ff[2*COEF_W-1:COEF_W];
      m[2] = pair23_ff[COEF_W-1:0];
      m[3] = pair23_ff[2*COEF_W-1:COEF_W];
      m[4] = pair45_ff[COEF_W-1:0];
      m[5] = pair45_ff[2*COEF_W-1:COEF_W];
      m[6] = pair67_ff[COEF_W-1:0];
      m[7] = pair67_ff[2*COEF_W-1:COEF_W];
      m[8] = coef8_ff;
   end

   assign en         = ~full;
   assign req_tready = en;
   assign push       = v3_ff & ~full;

   assign xs = {1'b0, x1_ff};
   assign ys = {1'b0, y1_ff};

   always_comb begin
      p_in[0] = PROD_W'(m[0]) * PROD_W'(xs);
      p_in[1] = PROD_W'(m[1]) * PROD_W'(ys);
      p_in[2] = PROD_W'(m[3]) * PROD_W'(xs);
      p_in[3] = PROD_W'(m[4]) * PROD_W'(ys);
      p_in[4] = PROD_W'(m[6]) * PROD_W'(xs);
      p_in[5] = PROD_W'(m[7]) * PROD_W'(ys);
      xp_in = SUM_W'(p_ff[0]) + SUM_W'(p_ff[1]) + SUM_W'(c2_ff);
      yp_in = SUM_W'(p_ff[2]) + SUM_W'(p_ff[3]) + SUM_W'(c5_ff);
      w_in  = SUM_W'(p_ff[4]) + SUM_W'(p_ff[5]) + SUM_W'(c8_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_tdata[COORD_BITS-1:0];
         y1_ff <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         for (int i = 0; i < 6; i++) begin
            p_ff[i] <= p_in[i];
         end
         c2_ff <= m[2];
         c5_ff <= m[5];
         c8_ff <= m[8];
         xp_ff <= xp_in;
         yp_ff <= yp_in;
         w_ff  <= w_in;
      end
   end

   // lowest bits: xp, then yp, then w (highest)
   assign push_data = {w_ff, yp_ff, xp_ff};

endmodule

// ===== src/pim_queue.sv =====
`include "perspective_inverse_map_defines.svh"

module pim_queue
   import pim_pkg::*;
#(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0]  wr_ff, rd_ff;
   logic [CNT_W-1:0]  count_ff;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   `PIM_NEVER(a_no_overflow, clock, reset, push && full, "queue written while full")
   `PIM_NEVER(a_no_underflow, clock, reset, pop && empty, "queue read while empty")
   `PIM_NEVER(a_count_range, clock, reset, count_ff > CNT_W'(DEPTH), "queue count past depth")
   `PIM_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count did not grow")

endmodule

// ===== src/pim_div.sv =====
module pim_div
   import pim_pkg::*;
#(
   parameter int SUM_W         = sum_width(COORD_BITS_DEF),
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [SUM_W-1:0] num,
   input  logic signed [SUM_W-1:0] den,
   output logic [OUT_W-1:0]        res,
   output logic                    sat
);

   localparam int CW = SUM_W + OUT_FRAC_BITS + OUT_W;

   logic [CW-1:0]    rem_ff [0:OUT_W];
   logic [SUM_W-1:0] d_ff   [0:OUT_W];
   logic [OUT_W-1:0] q_ff   [0:OUT_W];
   logic             neg_ff [0:OUT_W];
   logic             ovf_ff [0:OUT_W];

   logic [SUM_W-1:0] n_abs, d_abs;
   logic [CW-1:0]    n_sh;
   logic [OUT_W:0]   lim;
   logic             sat_c;
   logic [OUT_W-1:0] mag;

   assign n_abs = num[SUM_W-1] ? (~num + 1'b1) : num;
   assign d_abs = den[SUM_W-1] ? (~den + 1'b1) : den;
   assign n_sh  = CW'(n_abs) << OUT_FRAC_BITS;

   // quotient of 2^32 or more cannot fit, flag it up front
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= n_sh;
         d_ff[0]   <= d_abs;
         q_ff[0]   <= '0;
         neg_ff[0] <= num[SUM_W-1] ^ den[SUM_W-1];
         ovf_ff[0] <= (n_sh >= (CW'(d_abs) << OUT_W));
      end
   end

   for (genvar k = 0; k < OUT_W; k++) begin : g_stage
      logic [CW-1:0] cand;
      logic          ge;
      assign cand = CW'(d_ff[k]) << (OUT_W - 1 - k);
      assign ge   = (rem_ff[k] >= cand);
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= ge ? (rem_ff[k] - cand) : rem_ff[k];
            q_ff[k+1]   <= {q_ff[k][OUT_W-2:0], ge};
            d_ff[k+1]   <= d_ff[k];
            neg_ff[k+1] <= neg_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign lim   = {1'b0, neg_ff[OUT_W], {(OUT_W-1){~neg_ff[OUT_W]}}};
   assign sat_c = ovf_ff[OUT_W] | ({1'b0, q_ff[OUT_W]} > lim);
   assign mag   = sat_c ? lim[OUT_W-1:0] : q_ff[OUT_W];

   always_ff @(posedge clock) begin
      if (en) begin
         res <= neg_ff[OUT_W] ? (~mag + 1'b1) : mag;
         sat <= sat_c;
      end
   end

endmodule

// ===== src/pim_back.sv =====
module pim_back
   import pim_pkg::*;
#(
   parameter int SUM_W         = sum_width(COORD_BITS_DEF),
   parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [3*SUM_W-1:0]    pop_data,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*OUT_W-1:0]    rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   // divider: entry stage, one stage per quotient bit, saturation stage
   localparam int LAT = OUT_W + 2;

   logic             v_ff  [0:LAT-1];
   logic             wz_ff [0:LAT-1];
   logic             en;
   logic signed [SUM_W-1:0] xp, yp, w;
   logic [OUT_W-1:0] qx, qy;
   logic             sx, sy;

   assign xp  = pop_data[SUM_W-1:0];
   assign yp  = pop_data[2*SUM_W-1:SUM_W];
   assign w   = pop_data[3*SUM_W-1:2*SUM_W];
   assign en  = ~v_ff[LAT-1] | rsp_tready;
   assign pop = en & ~empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) v_ff[i] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= pop;
         for (int i = 1; i < LAT; i++) v_ff[i] <= v_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff[0] <= (w == '0);
         for (int i = 1; i < LAT; i++) wz_ff[i] <= wz_ff[i-1];
      end
   end

   pim_div #(.SUM_W(SUM_W), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_x (
      .clock(clock), .en(en), .num(xp), .den(w), .res(qx), .sat(sx)
   );

   pim_div #(.SUM_W(SUM_W), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div_y (
      .clock(clock), .en(en), .num(yp), .den(w), .res(qy), .sat(sy)
   );

   assign rsp_tvalid = v_ff[LAT-1];

   always_comb begin
      if (wz_ff[LAT-1]) begin
         rsp_tdata = '0;
         rsp_tuser = STATUS_WZERO;
      end else begin
         rsp_tdata = {qy, qx};
         rsp_tuser = (sx | sy) ? STATUS_SAT : STATUS_OK;
      end
   end

endmodule

// ===== src/perspective_inverse_map.sv =====
// Path from request to response valid: 3 front stages, the queue, 34 divider stages.
// Throughput: one transaction per cycle unless stalled, set by the fully
// pipelined bit-per-stage dividers for x and y sharing one stall enable.
// Reset: synchronous, active high; loads the identity matrix and empties
// the pipeline and queue.
module perspective_inverse_map
   import pim_pkg::*;
#(
   parameter int COORD_BITS     = COORD_BITS_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS  = OUT_FRAC_BITS_DEF,
   parameter int IN_W           = ((2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_W-1:0]       req_tdata,   // pix_x, pix_y
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [2*OUT_W-1:0]    rsp_tdata,   // src_x, src_y
   output logic [STATUS_W-1:0]   rsp_tuser,   // status
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUM_W = sum_width(COORD_BITS);

   logic               push, full, pop, empty;
   logic [3*SUM_W-1:0] push_data, pop_data;

   pim_front #(
      .COORD_BITS(COORD_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS),
      .IN_W(IN_W), .SUM_W(SUM_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .push(push), .push_data(push_data), .full(full)
   );

   pim_queue #(.DATA_W(3 * SUM_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(full),
      .pop(pop), .pop_data(pop_data), .empty(empty)
   );

   pim_back #(.SUM_W(SUM_W), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .pop_data(pop_data), .empty(empty), .pop(pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

endmodule
